[rtl/vr2d_pkg.sv]
// Shared widths, constants and the pipeline sideband type for the 2D vector reflector.
package vr2d_pkg;

  localparam int W         = 32;
  localparam int UNIT_BITS = W - 2;
  localparam int NORM_BITS = W - 1;
  localparam int SQ_BITS   = 2 * NORM_BITS + 1;
  localparam int D_BITS    = 2 * W + 1;
  localparam int DQ_BITS   = W + 3;
  localparam int T_BITS    = DQ_BITS + W;
  localparam int RT_BITS   = T_BITS - UNIT_BITS + 1;
  localparam int R_BITS    = RT_BITS + 1;
  localparam int LZ_BITS   = $clog2(W);

  typedef struct packed {
    logic signed [W-1:0]  vx;
    logic signed [W-1:0]  vy;
    logic [NORM_BITS-1:0] a;
    logic [NORM_BITS-1:0] b;
    logic                 sx;
    logic                 sy;
    logic                 zero;
  } vr2d_side_t;

endpackage

[rtl/vr2d_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
module vr2d_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ce,
  input  logic                          in_vld,
  input  logic [vr2d_pkg::SQ_BITS-1:0]  in_sum,
  input  vr2d_pkg::vr2d_side_t          in_side,
  output logic                          out_vld,
  output logic [vr2d_pkg::W-1:0]        out_root,
  output vr2d_pkg::vr2d_side_t          out_side
);
  import vr2d_pkg::*;

  logic           vld  [0:W];
  logic [2*W-1:0] sv   [0:W];
  logic [W+2:0]   rem  [0:W];
  logic [W-1:0]   root [0:W];
  vr2d_side_t     sd   [0:W];

  assign vld[0]  = in_vld;
  assign sv[0]   = (2*W)'(in_sum);
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sd[0]   = in_side;

  for (genvar g = 0; g < W; g++) begin : g_step
    logic [W+2:0] rsh;
    logic [W+2:0] trial;
    assign rsh   = {rem[g][W:0], sv[g][2*(W-1-g)+1 -: 2]};
    assign trial = {1'b0, root[g], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (ce) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        sv[g+1] <= sv[g];
        sd[g+1] <= sd[g];
        if (rsh >= trial) begin
          rem[g+1]  <= rsh - trial;
          root[g+1] <= {root[g][W-2:0], 1'b1};
        end else begin
          rem[g+1]  <= rsh;
          root[g+1] <= {root[g][W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld[W];
  assign out_root = root[W];
  assign out_side = sd[W];

endmodule

[rtl/vr2d_div.sv]
// Pipelined dual restoring divider forming the unit direction, one quotient bit per stage.
module vr2d_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            ce,
  input  logic                            in_vld,
  input  logic [vr2d_pkg::W-1:0]          in_mag,
  input  vr2d_pkg::vr2d_side_t            in_side,
  output logic                            out_vld,
  output logic [vr2d_pkg::NORM_BITS-1:0]  out_qa,
  output logic [vr2d_pkg::NORM_BITS-1:0]  out_qb,
  output vr2d_pkg::vr2d_side_t            out_side
);
  import vr2d_pkg::*;

  localparam int N = NORM_BITS;

  logic           vld [0:N];
  logic [W:0]     ra  [0:N];
  logic [W:0]     rb  [0:N];
  logic [N-1:0]   qa  [0:N];
  logic [N-1:0]   qb  [0:N];
  logic [W-1:0]   mag [0:N];
  vr2d_side_t     sd  [0:N];

  assign vld[0] = in_vld;
  assign ra[0]  = (W+1)'(in_side.a[N-1:1]);
  assign rb[0]  = (W+1)'(in_side.b[N-1:1]);
  assign qa[0]  = '0;
  assign qb[0]  = '0;
  assign mag[0] = in_mag;
  assign sd[0]  = in_side;

  for (genvar g = 0; g < N; g++) begin : g_step
    logic       na;
    logic       nb;
    logic [W:0] ta;
    logic [W:0] tb;
    assign na = (g == 0) ? sd[g].a[0] : 1'b0;
    assign nb = (g == 0) ? sd[g].b[0] : 1'b0;
    assign ta = {ra[g][W-1:0], na};
    assign tb = {rb[g][W-1:0], nb};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (ce) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        mag[g+1] <= mag[g];
        sd[g+1]  <= sd[g];
        if (ta >= {1'b0, mag[g]}) begin
          ra[g+1] <= ta - {1'b0, mag[g]};
          qa[g+1] <= {qa[g][N-2:0], 1'b1};
        end else begin
          ra[g+1] <= ta;
          qa[g+1] <= {qa[g][N-2:0], 1'b0};
        end
        if (tb >= {1'b0, mag[g]}) begin
          rb[g+1] <= tb - {1'b0, mag[g]};
          qb[g+1] <= {qb[g][N-2:0], 1'b1};
        end else begin
          rb[g+1] <= tb;
          qb[g+1] <= {qb[g][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld[N];
  assign out_qa   = qa[N];
  assign out_qb   = qb[N];
  assign out_side = sd[N];

endmodule

[rtl/vector_reflect_2d.sv]
// Top level: reflects a 2D fixed-point vector about a normalised direction.
// Pipeline from input transaction to result: normalise, square, sum,
// 32 square-root stages, 31 divider stages, two multiply stages and rounding.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register waits on m_tready.
// Reset: synchronous, active high; clears every valid bit, data is not reset.
module vector_reflect_2d (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // vec_x, vec_y, mirror_x, mirror_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // ref_x, ref_y
  output logic [1:0]   m_tuser    // zero_mirror, saturated
);
  import vr2d_pkg::*;

  typedef struct packed {
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [W-1:0] ux;
    logic signed [W-1:0] uy;
    logic                zero;
  } tail_t;

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  logic signed [W-1:0]  in_vx, in_vy, in_mx, in_my;
  logic [W-1:0]         ax, bx, big;
  logic [LZ_BITS-1:0]   lz;
  logic [NORM_BITS-1:0] an, bn;

  assign in_vx = s_tdata[W-1:0];
  assign in_vy = s_tdata[2*W-1:W];
  assign in_mx = s_tdata[3*W-1:2*W];
  assign in_my = s_tdata[4*W-1:3*W];
  assign ax    = in_mx[W-1] ? W'(-in_mx) : in_mx;
  assign bx    = in_my[W-1] ? W'(-in_my) : in_my;
  assign big   = (ax > bx) ? ax : bx;

  always_comb begin
    lz = '0;
    for (int i = 0; i < W - 1; i++) begin
      if (big[i]) lz = LZ_BITS'(W - 2 - i);
    end
    if (big[W-1]) begin
      an = ax[W-1:1];
      bn = bx[W-1:1];
    end else begin
      an = ax[NORM_BITS-1:0] << lz;
      bn = bx[NORM_BITS-1:0] << lz;
    end
  end

  logic                   v1, v2, v3;
  vr2d_side_t             sd1, sd2, sd3;
  logic [2*NORM_BITS-1:0] aa, bb;
  logic [SQ_BITS-1:0]     sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sd1.vx   <= in_vx;
      sd1.vy   <= in_vy;
      sd1.a    <= an;
      sd1.b    <= bn;
      sd1.sx   <= in_mx[W-1];
      sd1.sy   <= in_my[W-1];
      sd1.zero <= (ax == '0) && (bx == '0);
      aa       <= (2*NORM_BITS)'(sd1.a) * (2*NORM_BITS)'(sd1.a);
      bb       <= (2*NORM_BITS)'(sd1.b) * (2*NORM_BITS)'(sd1.b);
      sd2      <= sd1;
      sum      <= SQ_BITS'(aa) + SQ_BITS'(bb);
      sd3      <= sd2;
    end
  end

  logic       vs;
  logic [W-1:0] root;
  vr2d_side_t sds;

  vr2d_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_vld   (v3),
    .in_sum   (sum),
    .in_side  (sd3),
    .out_vld  (vs),
    .out_root (root),
    .out_side (sds)
  );

  logic                 vd;
  logic [NORM_BITS-1:0] qa, qb;
  vr2d_side_t           sdd;

  vr2d_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_vld   (vs),
    .in_mag   (root),
    .in_side  (sds),
    .out_vld  (vd),
    .out_qa   (qa),
    .out_qb   (qb),
    .out_side (sdd)
  );

  logic signed [W-1:0] ux_d, uy_d;
  assign ux_d = sdd.sx ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
  assign uy_d = sdd.sy ? -$signed({1'b0, qb}) : $signed({1'b0, qb});

  logic                      v4, v5, v6;
  tail_t                     t4, t5, t6;
  logic signed [2*W-1:0]     px, py;
  logic signed [D_BITS-1:0]  d5;
  logic [D_BITS-1:0]         dmag;
  logic [D_BITS-1:0]         dround;
  logic signed [DQ_BITS-1:0] dq;
  logic signed [T_BITS-1:0]  tx, ty;

  assign d5     = D_BITS'(px) + D_BITS'(py);
  assign dmag   = d5[D_BITS-1] ? D_BITS'(-d5) : d5;
  assign dround = (dmag + (D_BITS'(1) << (UNIT_BITS - 1))) >> UNIT_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (ce) begin
      v4 <= vd;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t4.vx   <= sdd.vx;
      t4.vy   <= sdd.vy;
      t4.ux   <= ux_d;
      t4.uy   <= uy_d;
      t4.zero <= sdd.zero;
      px      <= (2*W)'(sdd.vx) * (2*W)'(ux_d);
      py      <= (2*W)'(sdd.vy) * (2*W)'(uy_d);
      t5      <= t4;
      dq      <= d5[D_BITS-1] ? -$signed(DQ_BITS'(dround)) : $signed(DQ_BITS'(dround));
      t6      <= t5;
      tx      <= T_BITS'(dq) * T_BITS'(t5.ux);
      ty      <= T_BITS'(dq) * T_BITS'(t5.uy);
    end
  end

  logic [T_BITS-1:0]        txm, tym;
  logic [T_BITS-1:0]        txr, tyr;
  logic signed [RT_BITS-1:0] rtx, rty;
  logic signed [R_BITS-1:0]  rx, ry;
  logic                      clip_x, clip_y;
  logic signed [W-1:0]       ox, oy;

  assign txm = tx[T_BITS-1] ? T_BITS'(-tx) : tx;
  assign tym = ty[T_BITS-1] ? T_BITS'(-ty) : ty;
  assign txr = (txm + (T_BITS'(1) << (UNIT_BITS - 2))) >> (UNIT_BITS - 1);
  assign tyr = (tym + (T_BITS'(1) << (UNIT_BITS - 2))) >> (UNIT_BITS - 1);
  assign rtx = tx[T_BITS-1] ? -$signed(RT_BITS'(txr)) : $signed(RT_BITS'(txr));
  assign rty = ty[T_BITS-1] ? -$signed(RT_BITS'(tyr)) : $signed(RT_BITS'(tyr));
  assign rx  = R_BITS'(t6.vx) - R_BITS'(rtx);
  assign ry  = R_BITS'(t6.vy) - R_BITS'(rty);

  assign clip_x = (rx[R_BITS-1:W-1] != '0) && (rx[R_BITS-1:W-1] != '1);
  assign clip_y = (ry[R_BITS-1:W-1] != '0) && (ry[R_BITS-1:W-1] != '1);
  assign ox = clip_x ? {rx[R_BITS-1], {(W-1){!rx[R_BITS-1]}}} : rx[W-1:0];
  assign oy = clip_y ? {ry[R_BITS-1], {(W-1){!ry[R_BITS-1]}}} : ry[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (t6.zero) begin
        m_tdata <= {t6.vy, t6.vx};
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {oy, ox};
        m_tuser <= {clip_x || clip_y, 1'b0};
      end
    end
  end

  a_zero_no_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("zero direction result flagged as saturated");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(v6) && $stable(t6)))
    else $error("pipeline advanced during stall");

endmodule

[verif/tb_vector_reflect_2d.sv]
// Testbench for vector_reflect_2d: directed table vs stored or predicted results, random vectors vs predictor.
module tb_vector_reflect_2d;
  import vr2d_pkg::*;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] mx;
    logic [31:0] my;
  } reflect_in_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic        zero_mirror;
    logic        saturated;
  } reflect_out_t;

  typedef struct {
    reflect_in_t  stim;
    bit           known;
    reflect_out_t res;
  } table_row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_ITEMS   = 800;
  localparam logic [31:0] MIN_W = 32'h8000_0000;
  localparam logic [31:0] MAX_W = 32'h7fff_ffff;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;

  reflect_out_t reflect_q[$];
  int           fail_count;
  int           idle_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  table_row_t   dir_rows[$];

  vector_reflect_2d DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned abs_of(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint shift_round(longint x, int n);
    longint unsigned m;
    m = abs_of(x);
    m = (m + (64'd1 << (n - 1))) >> n;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic reflect_out_t reflect_vector(reflect_in_t i);
    reflect_out_t o;
    longint vx, vy, mx, my, ux, uy, d, dq, rx, ry;
    longint unsigned a, b, big, mag, top;
    longint hi, lo;
    vx = longint'($signed(i.vx));
    vy = longint'($signed(i.vy));
    mx = longint'($signed(i.mx));
    my = longint'($signed(i.my));
    o = '0;
    if (mx == 0 && my == 0) begin
      o.rx = i.vx;
      o.ry = i.vy;
      o.zero_mirror = 1'b1;
      return o;
    end
    a = abs_of(mx);
    b = abs_of(my);
    top = 64'd1 << UNIT_BITS;
    big = a > b ? a : b;
    if (big >= (top << 1)) begin
      a = a >> 1;
      b = b >> 1;
    end else begin
      while (big < top) begin
        a = a << 1;
        b = b << 1;
        big = big << 1;
      end
    end
    mag = root_floor(a * a + b * b);
    if (mag == 0) mag = 1;
    ux = longint'((a << UNIT_BITS) / mag);
    uy = longint'((b << UNIT_BITS) / mag);
    if (mx < 0) ux = -ux;
    if (my < 0) uy = -uy;
    d = vx * ux + vy * uy;
    dq = shift_round(d, UNIT_BITS);
    rx = vx - shift_round(2 * dq * ux, UNIT_BITS);
    ry = vy - shift_round(2 * dq * uy, UNIT_BITS);
    hi = 64'sd2147483647;
    lo = -hi - 1;
    if (rx > hi) begin rx = hi; o.saturated = 1'b1; end
    if (rx < lo) begin rx = lo; o.saturated = 1'b1; end
    if (ry > hi) begin ry = hi; o.saturated = 1'b1; end
    if (ry < lo) begin ry = lo; o.saturated = 1'b1; end
    o.rx = rx[31:0];
    o.ry = ry[31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return MIN_W;
      1: return MAX_W;
      2: return $urandom_range(0, 3) == 0 ? 32'd0 : 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'($signed($urandom()) >>> $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_vector(reflect_in_t i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {i.my, i.mx, i.vy, i.vx};
    reflect_q.push_back(reflect_vector(i));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic add_row(logic [31:0] vx, vy, mx, my, bit known = 0,
                         reflect_out_t res = '0);
    table_row_t r;
    r.stim  = '{vx, vy, mx, my};
    r.known = known;
    r.res   = res;
    dir_rows.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    reflect_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]};
      if (reflect_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], '0);
      end else begin
        want = reflect_q.pop_front();
        if (got.rx !== want.rx) report_mismatch("ref_x", got.rx, want.rx);
        if (got.ry !== want.ry) report_mismatch("ref_y", got.ry, want.ry);
        if (got.zero_mirror !== want.zero_mirror)
          report_mismatch("zero_mirror", 32'(got.zero_mirror), 32'(want.zero_mirror));
        if (got.saturated !== want.saturated)
          report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    reflect_in_t i;
    int drain;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_row(32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0, 1,
            '{32'h0001_0000, 32'h0002_0000, 1'b1, 1'b0});
    add_row(MIN_W, MAX_W, 32'd0, 32'd0, 1, '{MIN_W, MAX_W, 1'b1, 1'b0});
    add_row(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'd0, 1,
            '{32'hffff_0000, 32'h0002_0000, 1'b0, 1'b0});
    add_row(32'h0001_0000, 32'h0002_0000, 32'd0, 32'h0005_0000, 1,
            '{32'h0001_0000, 32'hfffe_0000, 1'b0, 1'b0});
    add_row(MIN_W, 32'd0, 32'h0001_0000, 32'd0, 1, '{MAX_W, 32'd0, 1'b0, 1'b1});
    add_row(MIN_W, MIN_W, MIN_W, MIN_W, 0);
    add_row(MAX_W, MAX_W, MAX_W, MAX_W, 0);
    add_row(MAX_W, MIN_W, MIN_W, MAX_W, 0);
    add_row(32'h0003_0000, 32'h0004_0000, 32'd1, 32'd1, 0);
    add_row(32'h0003_0000, 32'hfffc_0000, 32'hffff_ffff, 32'd0, 0);
    add_row(32'h1234_5678, 32'h8765_4321, MIN_W, 32'd0, 0);
    add_row(32'h1234_5678, 32'h8765_4321, 32'd0, MIN_W, 0);
    add_row(32'd1, 32'hffff_ffff, 32'd1, 32'd0, 0);
    add_row(MAX_W, MAX_W, 32'd1, 32'hffff_ffff, 0);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].known && reflect_vector(dir_rows[k].stim) !== dir_rows[k].res)
        $display("table row %0d disagrees with predictor", k);
      send_vector(dir_rows[k].stim);
      if (dir_rows[k].known) reflect_q[$] = dir_rows[k].res;
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n / (RANDOM_ITEMS / 5))
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        3: begin send_idle_pct = 32; recv_stall_pct = 32; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      i.vx = rand_word();
      i.vy = rand_word();
      i.mx = rand_word();
      i.my = rand_word();
      send_vector(i);
    end
    s_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (reflect_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
